[design/rwsp_pkg.sv]
// Shared types and constants for the RIFF/WAVE stream parser.
package rwsp_pkg;

	// Chunk and file tags, first byte of the file in the top byte.
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// Format tags and sample widths that the parser plays out.
	localparam logic [15:0] FMT_PCM    = 16'd1;
	localparam logic [15:0] FMT_FLOAT  = 16'd3;
	localparam logic [15:0] BITS_PCM   = 16'd16;
	localparam logic [15:0] BITS_FLOAT = 16'd32;

	// Smallest fmt chunk body that holds every captured field.
	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

	// Beat kinds carried in the low tuser bit.
	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Output tdata width: 84 bits of fields rounded up to whole bytes.
	localparam int TDATA_W = 88;
	localparam int TUSER_W = 2;

	// Default number of entries between the parser and the output stage.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_CHDR,
		PH_FMT,
		PH_SKIP,
		PH_DATA,
		PH_PAD,
		PH_HALT
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_NOT_WAVE    = 4'd1,
		ST_TRUNCATED   = 4'd2,
		ST_FMT_SMALL   = 4'd3,
		ST_NO_FMT      = 4'd4,
		ST_NO_DATA     = 4'd5,
		ST_ZERO_CHAN   = 4'd6,
		ST_UNSUPPORTED = 4'd7,
		ST_DATA_FIRST  = 4'd8
	} status_t;

	// One queue entry: everything a single input byte produces.
	typedef struct packed {
		logic        has_sample;
		logic        has_summary;
		logic [31:0] sample_word;
		logic        is_float;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		status_t     status;
	} entry_t;

endpackage

[design/rwsp_front.sv]
// Byte parser: walks the RIFF header and chunks and classifies each byte into a queue entry.
module rwsp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         file_byte,
	input  logic               end_of_file,
	output logic               q_valid,
	output rwsp_pkg::entry_t   q_data,
	input  logic               q_ready
);

	rwsp_pkg::phase_t  phase_q, phase_d;
	logic [3:0]        idx_q, idx_d;
	logic [31:0]       tag_q, tag_d;
	logic [31:0]       left_q, left_d;
	logic              odd_q, odd_d;
	logic [15:0]       fmtc_q, fmtc_d;
	logic [15:0]       chan_q, chan_d;
	logic [31:0]       rate_q, rate_d;
	logic [15:0]       bits_q, bits_d;
	logic [1:0]        seen_q, seen_d;
	logic [31:0]       shift_q, shift_d;
	logic [1:0]        scount_q, scount_d;
	rwsp_pkg::status_t err_q, err_d;

	logic              accept;
	logic              emit_sample;
	logic [31:0]       shift_put;
	logic              float_cur, pcm16_cur;
	logic              float_nxt, pcm16_nxt;
	rwsp_pkg::status_t end_status;

	function automatic logic [31:0] put_byte32(logic [31:0] word, logic [1:0] pos,
			logic [7:0] b);
		logic [31:0] w;
		w = word;
		case (pos)
			2'd0: w[7:0]   = b;
			2'd1: w[15:8]  = b;
			2'd2: w[23:16] = b;
			default: w[31:24] = b;
		endcase
		return w;
	endfunction

	function automatic logic [15:0] put_byte16(logic [15:0] word, logic pos, logic [7:0] b);
		logic [15:0] w;
		w = word;
		if (pos) begin
			w[15:8] = b;
		end else begin
			w[7:0] = b;
		end
		return w;
	endfunction

	assign in_ready  = q_ready;
	assign accept    = in_valid && in_ready;
	assign float_cur = (fmtc_q == rwsp_pkg::FMT_FLOAT) && (bits_q == rwsp_pkg::BITS_FLOAT);
	assign pcm16_cur = (fmtc_q == rwsp_pkg::FMT_PCM) && (bits_q == rwsp_pkg::BITS_PCM);
	assign float_nxt = (fmtc_d == rwsp_pkg::FMT_FLOAT) && (bits_d == rwsp_pkg::BITS_FLOAT);
	assign pcm16_nxt = (fmtc_d == rwsp_pkg::FMT_PCM) && (bits_d == rwsp_pkg::BITS_PCM);
	assign shift_put = put_byte32(shift_q, scount_q, file_byte);

	// Next state of the parser for the byte on the input.
	always_comb begin
		phase_d     = phase_q;
		idx_d       = idx_q;
		tag_d       = tag_q;
		left_d      = left_q;
		odd_d       = odd_q;
		fmtc_d      = fmtc_q;
		chan_d      = chan_q;
		rate_d      = rate_q;
		bits_d      = bits_q;
		seen_d      = seen_q;
		shift_d     = shift_q;
		scount_d    = scount_q;
		err_d       = err_q;
		emit_sample = 1'b0;
		unique case (phase_q)
			rwsp_pkg::PH_HDR: begin
				tag_d = {tag_q[23:0], file_byte};
				if (idx_q == 4'd3 && tag_d != rwsp_pkg::TAG_RIFF) begin
					err_d   = rwsp_pkg::ST_NOT_WAVE;
					phase_d = rwsp_pkg::PH_HALT;
				end else if (idx_q >= 4'd11) begin
					if (tag_d != rwsp_pkg::TAG_WAVE) begin
						err_d   = rwsp_pkg::ST_NOT_WAVE;
						phase_d = rwsp_pkg::PH_HALT;
					end else begin
						phase_d = rwsp_pkg::PH_CHDR;
						idx_d   = 4'd0;
					end
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			rwsp_pkg::PH_CHDR: begin
				if (idx_q < 4'd4) begin
					tag_d = {tag_q[23:0], file_byte};
					if (idx_q == 4'd0) begin
						left_d = '0;
					end
				end else begin
					left_d = put_byte32(left_q, idx_q[1:0], file_byte);
				end
				if (idx_q >= 4'd7) begin
					// Header complete: decide what the chunk body is.
					odd_d = left_d[0];
					idx_d = 4'd0;
					if (tag_d == rwsp_pkg::TAG_FMT) begin
						if (left_d < rwsp_pkg::FMT_MIN_SIZE) begin
							err_d   = rwsp_pkg::ST_FMT_SMALL;
							phase_d = rwsp_pkg::PH_HALT;
						end else begin
							seen_d[0] = 1'b1;
							phase_d   = rwsp_pkg::PH_FMT;
						end
					end else if (tag_d == rwsp_pkg::TAG_DATA) begin
						if (!seen_q[0]) begin
							err_d   = rwsp_pkg::ST_DATA_FIRST;
							phase_d = rwsp_pkg::PH_HALT;
						end else if (chan_q == 16'd0) begin
							err_d   = rwsp_pkg::ST_ZERO_CHAN;
							phase_d = rwsp_pkg::PH_HALT;
						end else if (!float_cur && !pcm16_cur) begin
							err_d   = rwsp_pkg::ST_UNSUPPORTED;
							phase_d = rwsp_pkg::PH_HALT;
						end else begin
							seen_d[1] = 1'b1;
							shift_d   = '0;
							scount_d  = 2'd0;
							phase_d   = (left_d == 32'd0) ? rwsp_pkg::PH_CHDR
								: rwsp_pkg::PH_DATA;
						end
					end else begin
						phase_d = (left_d == 32'd0) ? rwsp_pkg::PH_CHDR
							: rwsp_pkg::PH_SKIP;
					end
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			rwsp_pkg::PH_FMT: begin
				unique case (idx_q) inside
					[4'd0:4'd1]:   fmtc_d = put_byte16(fmtc_q, idx_q[0], file_byte);
					[4'd2:4'd3]:   chan_d = put_byte16(chan_q, idx_q[0], file_byte);
					[4'd4:4'd7]:   rate_d = put_byte32(rate_q, idx_q[1:0], file_byte);
					[4'd14:4'd15]: bits_d = put_byte16(bits_q, idx_q[0], file_byte);
					default: ;
				endcase
				left_d = left_q - 32'd1;
				if (left_q == 32'd1) begin
					phase_d = odd_q ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_CHDR;
					idx_d   = 4'd0;
				end else if (idx_q == 4'd15) begin
					phase_d = rwsp_pkg::PH_SKIP;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			rwsp_pkg::PH_SKIP: begin
				left_d = left_q - 32'd1;
				if (left_q == 32'd1) begin
					phase_d = odd_q ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_CHDR;
					idx_d   = 4'd0;
				end
			end
			rwsp_pkg::PH_DATA: begin
				emit_sample = float_cur ? (scount_q == 2'd3) : (scount_q != 2'd0);
				if (emit_sample) begin
					shift_d  = '0;
					scount_d = 2'd0;
				end else begin
					shift_d  = shift_put;
					scount_d = scount_q + 2'd1;
				end
				left_d = left_q - 32'd1;
				if (left_q == 32'd1) begin
					phase_d = odd_q ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_CHDR;
					idx_d   = 4'd0;
				end
			end
			rwsp_pkg::PH_PAD: begin
				phase_d = rwsp_pkg::PH_CHDR;
				idx_d   = 4'd0;
			end
			default: ;
		endcase
	end

	// Status of the file as it stands after this byte.
	always_comb begin
		if (err_d != rwsp_pkg::ST_OK) begin
			end_status = err_d;
		end else if (phase_d == rwsp_pkg::PH_HDR) begin
			end_status = rwsp_pkg::ST_NOT_WAVE;
		end else if (phase_d == rwsp_pkg::PH_FMT || phase_d == rwsp_pkg::PH_SKIP
				|| phase_d == rwsp_pkg::PH_DATA) begin
			end_status = rwsp_pkg::ST_TRUNCATED;
		end else if (!seen_d[0]) begin
			end_status = rwsp_pkg::ST_NO_FMT;
		end else if (!seen_d[1]) begin
			end_status = rwsp_pkg::ST_NO_DATA;
		end else if (chan_d == 16'd0) begin
			end_status = rwsp_pkg::ST_ZERO_CHAN;
		end else if (!float_nxt && !pcm16_nxt) begin
			end_status = rwsp_pkg::ST_UNSUPPORTED;
		end else begin
			end_status = rwsp_pkg::ST_OK;
		end
	end

	// Queue entry for the byte on the input.
	always_comb begin
		q_data.has_sample    = emit_sample;
		q_data.has_summary   = end_of_file;
		q_data.sample_word   = shift_put;
		q_data.is_float      = float_nxt;
		q_data.channel_count = chan_d;
		q_data.rate_hz       = rate_d;
		q_data.status        = end_status;
		q_valid              = in_valid && (emit_sample || end_of_file);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rwsp_pkg::PH_HDR;
			idx_q    <= '0;
			tag_q    <= '0;
			left_q   <= '0;
			odd_q    <= 1'b0;
			fmtc_q   <= '0;
			chan_q   <= '0;
			rate_q   <= '0;
			bits_q   <= '0;
			seen_q   <= '0;
			shift_q  <= '0;
			scount_q <= '0;
			err_q    <= rwsp_pkg::ST_OK;
		end else if (accept) begin
			if (end_of_file) begin
				phase_q  <= rwsp_pkg::PH_HDR;
				idx_q    <= '0;
				tag_q    <= '0;
				left_q   <= '0;
				odd_q    <= 1'b0;
				fmtc_q   <= '0;
				chan_q   <= '0;
				rate_q   <= '0;
				bits_q   <= '0;
				seen_q   <= '0;
				shift_q  <= '0;
				scount_q <= '0;
				err_q    <= rwsp_pkg::ST_OK;
			end else begin
				phase_q  <= phase_d;
				idx_q    <= idx_d;
				tag_q    <= tag_d;
				left_q   <= left_d;
				odd_q    <= odd_d;
				fmtc_q   <= fmtc_d;
				chan_q   <= chan_d;
				rate_q   <= rate_d;
				bits_q   <= bits_d;
				seen_q   <= seen_d;
				shift_q  <= shift_d;
				scount_q <= scount_d;
				err_q    <= err_d;
			end
		end
	end

endmodule

[design/rwsp_queue.sv]
// Small first-in first-out queue of parser entries between the front and back parts.
module rwsp_queue #(
	parameter int DEPTH = rwsp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rwsp_pkg::entry_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rwsp_pkg::entry_t out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rwsp_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[design/rwsp_back.sv]
// Output stage: holds one entry and plays it out as one or two stream beats.
module rwsp_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rwsp_pkg::entry_t                 in_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rwsp_pkg::TDATA_W-1:0]     m_tdata,
	output logic [rwsp_pkg::TUSER_W-1:0]     m_tuser,
	output logic                             m_tlast
);

	rwsp_pkg::entry_t ent_q;
	logic             pend_sample_q, pend_summary_q;
	logic             fire, last_beat, load, summary_beat;

	assign m_tvalid     = pend_sample_q || pend_summary_q;
	assign fire         = m_tvalid && m_tready;
	assign last_beat    = fire && !(pend_sample_q && pend_summary_q);
	assign load         = in_valid && (!m_tvalid || last_beat);
	assign in_ready     = load;
	assign summary_beat = !pend_sample_q;

	// A sample beat goes out before the summary of the same byte.
	always_comb begin
		if (summary_beat) begin
			m_tdata = {4'd0, ent_q.status, ent_q.rate_hz, ent_q.channel_count, 32'd0};
			m_tuser = {ent_q.is_float, rwsp_pkg::KIND_SUMMARY};
		end else begin
			m_tdata = {4'd0, rwsp_pkg::ST_OK, ent_q.rate_hz, ent_q.channel_count,
				ent_q.sample_word};
			m_tuser = {ent_q.is_float, rwsp_pkg::KIND_SAMPLE};
		end
		m_tlast = summary_beat;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_sample_q  <= 1'b0;
			pend_summary_q <= 1'b0;
		end else if (load) begin
			pend_sample_q  <= in_data.has_sample;
			pend_summary_q <= in_data.has_summary;
		end else if (fire) begin
			if (pend_sample_q) begin
				pend_sample_q <= 1'b0;
			end else begin
				pend_summary_q <= 1'b0;
			end
		end
	end

endmodule

[design/riff_wave_stream_parser.sv]
// Top level of the RIFF/WAVE stream parser: byte parser, entry queue and output stage.
//
// The parser takes a WAV file one byte per beat on the s_ stream, tlast marking the
// final byte, and accepts one byte every clock: the byte parser works out each byte
// combinationally; s_tready drops only while the entry queue (QUEUE_DEPTH entries)
// is full because the m_ side is stalled. It checks the RIFF and WAVE tags, walks
// the little-endian chunks, captures the format tag, channel count, sample rate and
// bits per sample from the fmt chunk, and in each data chunk sends every complete
// 16-bit PCM sample (raw Q1.15 in the low half of the word) or 32-bit float sample
// (raw IEEE bits) as soon as its last byte arrives. The final byte of a file always
// yields one summary beat with the status and m_tlast high, after any sample that
// same byte completes; the next byte starts a new file. The m_ side sends one beat
// per clock while m_tready is high, so a byte that both completes a sample and ends
// the file yields two output beats, which the queue absorbs. A result passes through
// the entry queue and then the output stage register before its m_tvalid rises.
// Errors are sticky: after the first one the rest of the file is ignored and the
// summary carries that error's code.
module riff_wave_stream_parser #(
	parameter int QUEUE_DEPTH = rwsp_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Byte input. tdata: [7:0] file_byte. tlast: end_of_file.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tlast,
	// Result output. tdata: [31:0] sample_word, [47:32] channel_count,
	// [79:48] rate_hz, [83:80] status, [87:84] zero.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rwsp_pkg::TDATA_W-1:0]  m_tdata,
	// tuser: [0] item_kind, [1] is_float.
	output logic [rwsp_pkg::TUSER_W-1:0]  m_tuser,
	// tlast: last, high on the summary beat of each file.
	output logic                          m_tlast
);

	// Entries travel from the parser into the queue as soon as a byte is taken.
	logic             fq_valid, fq_ready;
	rwsp_pkg::entry_t fq_data;

	// And from the queue into the output stage when it frees up.
	logic             qb_valid, qb_ready;
	rwsp_pkg::entry_t qb_data;

	rwsp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.file_byte   (s_tdata),
		.end_of_file (s_tlast),
		.q_valid     (fq_valid),
		.q_data      (fq_data),
		.q_ready     (fq_ready)
	);

	rwsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	rwsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qb_valid),
		.in_ready (qb_ready),
		.in_data  (qb_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[dv/tb_riff_wave_stream_parser.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the RIFF/WAVE stream parser.
module tb_riff_wave_stream_parser;

	// A long silence on both streams means the parser has hung.
	localparam int STALL_LIMIT = 2000;
	// Length of the forced receiver hold-off in the backpressure test.
	localparam int HOLD_CYCLES = 90;
	// Stream of random bytes that the random part feeds in, roughly.
	localparam int RANDOM_BYTES = 120;
	// Data bytes in the backpressure file.
	localparam int PRESSURE_BYTES = 32;
	// A chunk tag that the parser has to skip over.
	localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
	// Receiver behaviors, chosen at random for stretches of cycles.
	localparam int RX_STEADY = 0;
	localparam int RX_RANDOM = 1;
	localparam int RX_THIRD  = 2;

	// One result beat as the checker sees it, fields unpacked.
	typedef struct {
		logic        kind;
		logic [31:0] word;
		logic        flt;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [3:0]  status;
		logic        last;
	} beat_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = 8'h00;
	logic                          s_tlast = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [rwsp_pkg::TDATA_W-1:0]  m_tdata;
	logic [rwsp_pkg::TUSER_W-1:0]  m_tuser;
	logic                          m_tlast;

	riff_wave_stream_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser state as the testbench tracks it, one copy of every register
	// the block keeps between bytes.
	// ------------------------------------------------------------------
	rwsp_pkg::phase_t  p_phase;
	logic [3:0]        p_idx;
	logic [31:0]       p_tag;
	logic [31:0]       p_left;
	logic              p_pad;
	logic [15:0]       p_fmt;
	logic [15:0]       p_chans;
	logic [31:0]       p_rate;
	logic [15:0]       p_bits;
	logic              p_fmt_seen;
	logic              p_data_seen;
	logic [31:0]       p_word;
	logic [1:0]        p_cnt;
	rwsp_pkg::status_t p_err;

	// Beats the parser still owes us, oldest first.
	beat_t predicted_beats[$];

	// Bytes of the file being built, first byte at the front.
	logic [7:0] file_buf[$];

	int  mismatch_count = 0;
	int  files_sent = 0;
	int  bytes_sent = 0;
	int  samples_checked = 0;
	int  summaries_checked = 0;
	logic [8:0] status_seen = '0;

	// Sender pacing: bursts of beats with gaps, unless held steady.
	bit  sender_steady = 1'b0;
	int  burst_left = 0;

	// Receiver pacing and the forced hold-off.
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  rx_mode = RX_STEADY;
	int  mode_left = 0;
	int  rx_tick = 0;

	int  idle_cycles = 0;
	beat_t want;

	function automatic logic cap_is_float();
		return p_fmt == rwsp_pkg::FMT_FLOAT && p_bits == rwsp_pkg::BITS_FLOAT;
	endfunction

	function automatic logic cap_is_pcm16();
		return p_fmt == rwsp_pkg::FMT_PCM && p_bits == rwsp_pkg::BITS_PCM;
	endfunction

	task automatic clear_parser_state();
		p_phase = rwsp_pkg::PH_HDR;
		p_idx = '0;
		p_tag = '0;
		p_left = '0;
		p_pad = 1'b0;
		p_fmt = '0;
		p_chans = '0;
		p_rate = '0;
		p_bits = '0;
		p_fmt_seen = 1'b0;
		p_data_seen = 1'b0;
		p_word = '0;
		p_cnt = '0;
		p_err = rwsp_pkg::ST_OK;
	endtask

	// The first error parks the parser until the end of the file.
	task automatic halt(input rwsp_pkg::status_t code);
		p_err = code;
		p_phase = rwsp_pkg::PH_HALT;
	endtask

	// A chunk body is done; an odd size still owes one pad byte.
	task automatic finish_body();
		p_phase = p_pad ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_CHDR;
		p_idx = '0;
	endtask

	task automatic push_beat(input logic kind, input logic [31:0] word,
			input rwsp_pkg::status_t st, input logic last);
		beat_t b;
		b.kind = kind;
		b.word = word;
		b.flt = cap_is_float();
		b.chans = p_chans;
		b.rate = p_rate;
		b.status = st;
		b.last = last;
		predicted_beats.push_back(b);
	endtask

	// Advances the tracked state by one accepted byte and queues the beats
	// that byte should produce: at most a sample and then a summary.
	task automatic parse_wave_byte(input logic [7:0] b, input logic eof);
		int k;
		int need;
		rwsp_pkg::status_t st;
		k = int'(p_idx);
		case (p_phase)
			rwsp_pkg::PH_HDR: begin
				p_tag = {p_tag[23:0], b};
				if (k == 3 && p_tag != rwsp_pkg::TAG_RIFF) begin
					halt(rwsp_pkg::ST_NOT_WAVE);
				end else if (k >= 11) begin
					if (p_tag != rwsp_pkg::TAG_WAVE) begin
						halt(rwsp_pkg::ST_NOT_WAVE);
					end else begin
						p_phase = rwsp_pkg::PH_CHDR;
						p_idx = '0;
					end
				end else begin
					p_idx = p_idx + 1'b1;
				end
			end
			rwsp_pkg::PH_CHDR: begin
				if (k < 4) begin
					p_tag = {p_tag[23:0], b};
					if (k == 0)
						p_left = '0;
				end else begin
					p_left[(k - 4) * 8 +: 8] = b;
				end
				if (k >= 7) begin
					// Whole chunk header in: decide what the body is.
					p_pad = p_left[0];
					p_idx = '0;
					if (p_tag == rwsp_pkg::TAG_FMT) begin
						if (p_left < rwsp_pkg::FMT_MIN_SIZE) begin
							halt(rwsp_pkg::ST_FMT_SMALL);
						end else begin
							p_fmt_seen = 1'b1;
							p_phase = rwsp_pkg::PH_FMT;
						end
					end else if (p_tag == rwsp_pkg::TAG_DATA) begin
						if (!p_fmt_seen)
							halt(rwsp_pkg::ST_DATA_FIRST);
						else if (p_chans == 16'd0)
							halt(rwsp_pkg::ST_ZERO_CHAN);
						else if (!cap_is_float() && !cap_is_pcm16())
							halt(rwsp_pkg::ST_UNSUPPORTED);
						else begin
							p_data_seen = 1'b1;
							p_word = '0;
							p_cnt = '0;
							if (p_left == 32'd0)
								finish_body();
							else
								p_phase = rwsp_pkg::PH_DATA;
						end
					end else begin
						if (p_left == 32'd0)
							finish_body();
						else
							p_phase = rwsp_pkg::PH_SKIP;
					end
				end else begin
					p_idx = p_idx + 1'b1;
				end
			end
			rwsp_pkg::PH_FMT: begin
				// Byte rate and block align (offsets 8 to 13) are not kept.
				if (k < 2)
					p_fmt[k * 8 +: 8] = b;
				else if (k < 4)
					p_chans[(k - 2) * 8 +: 8] = b;
				else if (k < 8)
					p_rate[(k - 4) * 8 +: 8] = b;
				else if (k >= 14)
					p_bits[(k - 14) * 8 +: 8] = b;
				p_left = p_left - 32'd1;
				if (p_left == 32'd0)
					finish_body();
				else if (k >= 15)
					p_phase = rwsp_pkg::PH_SKIP;
				else
					p_idx = p_idx + 1'b1;
			end
			rwsp_pkg::PH_SKIP: begin
				p_left = p_left - 32'd1;
				if (p_left == 32'd0)
					finish_body();
			end
			rwsp_pkg::PH_DATA: begin
				need = cap_is_float() ? 4 : 2;
				p_word[int'(p_cnt) * 8 +: 8] = b;
				if (int'(p_cnt) + 1 >= need) begin
					push_beat(rwsp_pkg::KIND_SAMPLE, p_word, rwsp_pkg::ST_OK, 1'b0);
					p_word = '0;
					p_cnt = '0;
				end else begin
					p_cnt = p_cnt + 1'b1;
				end
				p_left = p_left - 32'd1;
				if (p_left == 32'd0)
					finish_body();
			end
			rwsp_pkg::PH_PAD: begin
				p_phase = rwsp_pkg::PH_CHDR;
				p_idx = '0;
			end
			default: begin
			end
		endcase

		if (eof) begin
			// An end inside a chunk header or before the pad byte is fine;
			// an end inside a body is a truncated file.
			if (p_err != rwsp_pkg::ST_OK)
				st = p_err;
			else if (p_phase == rwsp_pkg::PH_HDR)
				st = rwsp_pkg::ST_NOT_WAVE;
			else if (p_phase == rwsp_pkg::PH_FMT || p_phase == rwsp_pkg::PH_SKIP
					|| p_phase == rwsp_pkg::PH_DATA)
				st = rwsp_pkg::ST_TRUNCATED;
			else if (!p_fmt_seen)
				st = rwsp_pkg::ST_NO_FMT;
			else if (!p_data_seen)
				st = rwsp_pkg::ST_NO_DATA;
			else if (p_chans == 16'd0)
				st = rwsp_pkg::ST_ZERO_CHAN;
			else if (!cap_is_float() && !cap_is_pcm16())
				st = rwsp_pkg::ST_UNSUPPORTED;
			else
				st = rwsp_pkg::ST_OK;
			push_beat(rwsp_pkg::KIND_SUMMARY, 32'h0, st, 1'b1);
			clear_parser_state();
		end
	endtask

	// ------------------------------------------------------------------
	// File building: tags go out first byte first, numbers little-endian.
	// ------------------------------------------------------------------
	task automatic put_tag(input logic [31:0] t);
		file_buf.push_back(t[31:24]);
		file_buf.push_back(t[23:16]);
		file_buf.push_back(t[15:8]);
		file_buf.push_back(t[7:0]);
	endtask

	task automatic put_le(input logic [31:0] v, input int n);
		int i;
		for (i = 0; i < n; i++)
			file_buf.push_back(v[i * 8 +: 8]);
	endtask

	task automatic start_file();
		file_buf.delete();
		put_tag(rwsp_pkg::TAG_RIFF);
		put_le($urandom, 4);
		put_tag(rwsp_pkg::TAG_WAVE);
	endtask

	// A chunk with random body bytes and its pad byte.
	task automatic put_chunk(input logic [31:0] tag, input int size);
		int i;
		put_tag(tag);
		put_le(size, 4);
		for (i = 0; i < size + (size % 2); i++)
			file_buf.push_back(8'($urandom));
	endtask

	// An fmt chunk; bytes past the standard sixteen are random filler.
	task automatic put_fmt(input logic [15:0] ftag, input logic [15:0] chans,
			input logic [31:0] rate, input logic [15:0] bits, input int size);
		logic [127:0] body;
		int i;
		body = {bits, 16'($urandom), 32'($urandom), rate, chans, ftag};
		put_tag(rwsp_pkg::TAG_FMT);
		put_le(size, 4);
		for (i = 0; i < size + (size % 2); i++)
			file_buf.push_back(i < 16 ? body[i * 8 +: 8] : 8'($urandom));
	endtask

	task automatic cut_file(input int keep);
		while (file_buf.size() > keep)
			void'(file_buf.pop_back());
	endtask

	// ------------------------------------------------------------------
	// Sending. Each beat waits for its handshake; the byte goes into the
	// tracked state at the edge where it is taken.
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [7:0] b, input logic eof);
		if (!sender_steady && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eof;
		do
			@(posedge clk);
		while (!s_tready);
		parse_wave_byte(b, eof);
		if (burst_left > 0)
			burst_left--;
		bytes_sent++;
	endtask

	task automatic send_file();
		int i;
		for (i = 0; i < file_buf.size(); i++)
			send_beat(file_buf[i], i == file_buf.size() - 1);
		files_sent++;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stretches of steady, random and one-in-three ready,
	// overridden by a hold-off when a test asks for one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(RX_STEADY, RX_THIRD);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			rx_tick++;
			case (rx_mode)
				RX_STEADY: m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
				default:   m_tready <= (rx_tick % 3 == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result checking against the oldest predicted beat.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s mismatch: expected %h, got %h", name, exp_val, got_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_beats.size() == 0) begin
				$error("beat with nothing predicted: tdata %h tuser %b tlast %b",
					m_tdata, m_tuser, m_tlast);
				mismatch_count++;
			end else begin
				want = predicted_beats.pop_front();
				check_field("item_kind", 32'(want.kind), 32'(m_tuser[0]));
				check_field("sample_word", want.word, m_tdata[31:0]);
				check_field("is_float", 32'(want.flt), 32'(m_tuser[1]));
				check_field("channel_count", 32'(want.chans), 32'(m_tdata[47:32]));
				check_field("rate_hz", want.rate, m_tdata[79:48]);
				check_field("status", 32'(want.status), 32'(m_tdata[83:80]));
				check_field("last", 32'(want.last), 32'(m_tlast));
				if (want.kind == rwsp_pkg::KIND_SUMMARY) begin
					summaries_checked++;
					status_seen[want.status] = 1'b1;
				end else begin
					samples_checked++;
				end
			end
		end
	end

	// Watchdog: any beat taken on either stream counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("riff_wave_stream_parser test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Files that never get past the RIFF/WAVE header.
	task automatic test_header_checks();
		// A one-byte file, and one cut off after eight bytes.
		file_buf.delete();
		file_buf.push_back(8'h52);
		send_file();
		start_file();
		cut_file(8);
		send_file();
		// Last letter of RIFF wrong: the rest of the file is ignored.
		file_buf.delete();
		put_tag(rwsp_pkg::TAG_RIFF ^ 32'h1);
		put_le(32'h24, 4);
		put_tag(rwsp_pkg::TAG_WAVE);
		put_fmt(rwsp_pkg::FMT_PCM, 16'd1, 32'd8000, rwsp_pkg::BITS_PCM, 16);
		send_file();
		// WAVE tag wrong in its first letter.
		file_buf.delete();
		put_tag(rwsp_pkg::TAG_RIFF);
		put_le(32'hFFFF_FFFF, 4);
		put_tag(rwsp_pkg::TAG_WAVE ^ 32'h8000_0000);
		put_chunk(TAG_LIST, 2);
		send_file();
	endtask

	// PCM at the field extremes; the last sample completes on the final
	// byte, so that byte yields a sample and then the summary.
	task automatic test_pcm_samples();
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, rwsp_pkg::BITS_PCM, 16);
		put_tag(rwsp_pkg::TAG_DATA);
		put_le(32'd8, 4);
		put_le(32'h8000, 2);
		put_le(32'h7FFF, 2);
		put_le(32'h0000, 2);
		put_le(32'hFFFF, 2);
		send_file();
	endtask

	// Float samples after an odd skipped chunk and a long fmt chunk, an
	// empty data chunk, then an odd data chunk whose stray byte is dropped
	// and whose pad byte never comes.
	task automatic test_float_samples();
		start_file();
		put_chunk(TAG_LIST, 3);
		put_fmt(rwsp_pkg::FMT_FLOAT, 16'd1, 32'd0, rwsp_pkg::BITS_FLOAT, 18);
		put_tag(rwsp_pkg::TAG_DATA);
		put_le(32'd8, 4);
		put_le(32'h7F80_0000, 4);
		put_le(32'hFF80_0000, 4);
		put_tag(rwsp_pkg::TAG_DATA);
		put_le(32'd0, 4);
		put_tag(rwsp_pkg::TAG_DATA);
		put_le(32'd5, 4);
		put_le(32'h8000_0001, 4);
		file_buf.push_back(8'hA5);
		send_file();
	endtask

	// Every status that a bad fmt or data arrangement produces.
	task automatic test_format_errors();
		// fmt too small, even though its body is cut short as well.
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'd2, 32'd48000, rwsp_pkg::BITS_PCM, 14);
		cut_file(file_buf.size() - 6);
		send_file();
		// Data ahead of fmt; the valid fmt after it changes nothing.
		start_file();
		put_chunk(rwsp_pkg::TAG_DATA, 4);
		put_fmt(rwsp_pkg::FMT_PCM, 16'd2, 32'd44100, rwsp_pkg::BITS_PCM, 16);
		send_file();
		// Zero channels and an unsupported width, both at the data header.
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'd0, 32'd22050, rwsp_pkg::BITS_PCM, 16);
		put_chunk(rwsp_pkg::TAG_DATA, 4);
		send_file();
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'd2, 32'd96000, 16'd24, 16);
		put_chunk(rwsp_pkg::TAG_DATA, 6);
		send_file();
		// No fmt at all, and fmt without data.
		start_file();
		put_chunk(TAG_LIST, 4);
		send_file();
		start_file();
		put_fmt(rwsp_pkg::FMT_FLOAT, 16'd2, 32'd48000, rwsp_pkg::BITS_FLOAT, 16);
		send_file();
		// A later fmt spoils a file that already played data.
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'd1, 32'd8000, rwsp_pkg::BITS_PCM, 16);
		put_chunk(rwsp_pkg::TAG_DATA, 2);
		put_fmt(rwsp_pkg::FMT_PCM, 16'd0, 32'd8000, rwsp_pkg::BITS_PCM, 16);
		send_file();
		start_file();
		put_fmt(rwsp_pkg::FMT_FLOAT, 16'd1, 32'd8000, rwsp_pkg::BITS_FLOAT, 16);
		put_chunk(rwsp_pkg::TAG_DATA, 4);
		put_fmt(rwsp_pkg::FMT_FLOAT, 16'd1, 32'd8000, rwsp_pkg::BITS_PCM, 16);
		send_file();
	endtask

	// Ends in the middle of a body versus between chunks.
	task automatic test_truncation();
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'd1, 32'd16000, rwsp_pkg::BITS_PCM, 16);
		put_tag(rwsp_pkg::TAG_DATA);
		put_le(32'd10, 4);
		put_le(32'h1234_5678, 4);
		send_file();
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'd1, 32'd16000, rwsp_pkg::BITS_PCM, 16);
		cut_file(12 + 8 + 6);
		send_file();
		start_file();
		put_chunk(TAG_LIST, 10);
		cut_file(12 + 8 + 3);
		send_file();
		// Trailing half chunk header after a complete data chunk.
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'd1, 32'd16000, rwsp_pkg::BITS_PCM, 16);
		put_chunk(rwsp_pkg::TAG_DATA, 4);
		file_buf.push_back(8'h64);
		file_buf.push_back(8'h61);
		send_file();
	endtask

	// The receiver holds off for a long stretch while a steady sender keeps
	// offering PCM bytes, so the entry queue fills and s_tready drops.
	task automatic test_backpressure();
		int i;
		sender_steady = 1'b1;
		start_file();
		put_fmt(rwsp_pkg::FMT_PCM, 16'd2, 32'd44100, rwsp_pkg::BITS_PCM, 16);
		put_tag(rwsp_pkg::TAG_DATA);
		put_le(PRESSURE_BYTES, 4);
		for (i = 0; i < PRESSURE_BYTES; i++)
			file_buf.push_back(8'($urandom));
		hold_req = 1'b1;
		send_file();
		sender_steady = 1'b0;
	endtask

	// Mostly well-formed files with random content and random formats,
	// some broken or cut, plus a share of pure noise.
	task automatic build_random_file();
		int pick;
		int width;
		int size;
		int fsize;
		logic [15:0] ftag;
		logic [15:0] fbits;
		logic [15:0] chans;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			file_buf.delete();
			if ($urandom_range(0, 1))
				put_tag(rwsp_pkg::TAG_RIFF);
			size = $urandom_range(1, 16);
			repeat (size) file_buf.push_back(8'($urandom));
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					ftag = rwsp_pkg::FMT_PCM;
					fbits = rwsp_pkg::BITS_PCM;
				end
				5, 6, 7, 8: begin
					ftag = rwsp_pkg::FMT_FLOAT;
					fbits = rwsp_pkg::BITS_FLOAT;
				end
				default: begin
					ftag = 16'($urandom_range(0, 4));
					fbits = 16'(8 * $urandom_range(1, 4));
				end
			endcase
			case ($urandom_range(0, 19))
				0: chans = 16'd0;
				1: chans = 16'hFFFF;
				2: chans = 16'($urandom);
				default: chans = 16'($urandom_range(1, 8));
			endcase
			width = (ftag == rwsp_pkg::FMT_FLOAT && fbits == rwsp_pkg::BITS_FLOAT) ? 4 : 2;
			fsize = 16;
			case ($urandom_range(0, 19))
				0: fsize = $urandom_range(0, 15);
				1, 2, 3: fsize = 16 + $urandom_range(1, 5);
				default: begin
				end
			endcase
			size = $urandom_range(0, 12) * width;
			if ($urandom_range(0, 4) == 0)
				size += $urandom_range(1, width - 1);

			start_file();
			if ($urandom_range(0, 3) == 0)
				put_chunk($urandom_range(0, 1) ? TAG_LIST : 32'($urandom),
					$urandom_range(0, 7));
			if (pick < 12)
				put_chunk(rwsp_pkg::TAG_DATA, size);
			put_fmt(ftag, chans, $urandom, fbits, fsize);
			put_chunk(rwsp_pkg::TAG_DATA, size);
			if ($urandom_range(0, 3) == 0)
				put_chunk(rwsp_pkg::TAG_DATA, $urandom_range(0, 3) * width);
			if ($urandom_range(0, 4) == 0)
				put_chunk(TAG_LIST, $urandom_range(0, 5));

			if ($urandom_range(0, 9) == 0)
				cut_file($urandom_range(1, file_buf.size()));
			if ($urandom_range(0, 14) == 0)
				file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom);
		end
	endtask

	task automatic test_random_files();
		int sent;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			sender_steady = ($urandom_range(0, 3) == 0);
			build_random_file();
			sent += file_buf.size();
			send_file();
		end
		sender_steady = 1'b0;
	endtask

	initial begin
		clear_parser_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_checks();
		test_pcm_samples();
		test_float_samples();
		test_format_errors();
		test_truncation();
		test_backpressure();
		test_random_files();

		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		// Drain, then leave room for any stray beat to show up.
		while (predicted_beats.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d files (%0d bytes): %0d samples and %0d summaries checked.",
			files_sent, bytes_sent, samples_checked, summaries_checked);
		$display("Summary status codes seen, one bit per code from ok upward: %b",
			status_seen);
		if (mismatch_count == 0) begin
			$display("riff_wave_stream_parser test passed");
		end else begin
			$display("riff_wave_stream_parser test failed");
		end
		$finish;
	end

endmodule
